// ===== rtl/core/pfp_pkg.sv =====
// Shared constants and types for the plane-from-three-points block.
// No dependencies; every other file in rtl/core refers to this package.
package pfp_pkg;

  localparam int DEF_COORD_WIDTH      = 32;
  localparam int DEF_NORMAL_FRAC_BITS = 30;
  localparam int COORD_FRAC_BITS      = 16;

  localparam int                     LIMIT_WIDTH = 32;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(7);
  localparam int                     THR_WIDTH   = 2 * LIMIT_WIDTH + 2 * COORD_FRAC_BITS;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== rtl/core/pfp_ifs.sv =====
// Valid/ready channel interfaces for the point triple and the plane result.
// Depends on pfp_pkg for default widths.
interface pfp_pts_if #(
  parameter int COORD_WIDTH = pfp_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;
  logic signed [COORD_WIDTH-1:0] third_x;
  logic signed [COORD_WIDTH-1:0] third_y;
  logic signed [COORD_WIDTH-1:0] third_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    output ready
  );
endinterface

interface pfp_plane_if #(
  parameter int COORD_WIDTH      = pfp_pkg::DEF_COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = pfp_pkg::DEF_NORMAL_FRAC_BITS
);
  logic                               valid;
  logic                               ready;
  logic signed [NORMAL_FRAC_BITS+1:0] normal_x;
  logic signed [NORMAL_FRAC_BITS+1:0] normal_y;
  logic signed [NORMAL_FRAC_BITS+1:0] normal_z;
  logic signed [COORD_WIDTH-1:0]      offset;
  logic                               degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, offset, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, offset, degenerate,
    output ready
  );
endinterface

// ===== rtl/core/pfp_queue.sv =====
// Small register queue that decouples the front and back pipelines.
// Depends on pfp_pkg for the status struct and default depth.
module pfp_queue #(
  parameter int  WIDTH = 1,
  parameter int  DEPTH = pfp_pkg::QUEUE_DEPTH,
  localparam int PTRW  = $clog2(DEPTH),
  localparam int CNTW  = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output pfp_pkg::queue_stat_t stat
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTRW'(DEPTH - 1)) ? '0 : wp_r + PTRW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTRW'(DEPTH - 1)) ? '0 : rp_r + PTRW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == CNTW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== rtl/core/pfp_front.sv =====
// Front pipeline: edge vectors, exact cross product, squared length and
// the degenerate test. Depends on pfp_pkg and pfp_ifs; feeds pfp_queue.
module pfp_front #(
  parameter int  COORD_WIDTH = pfp_pkg::DEF_COORD_WIDTH,
  localparam int CW     = COORD_WIDTH,
  localparam int EW     = CW + 1,
  localparam int CMW    = 2 * CW + 2,
  localparam int H      = CMW / 2,
  localparam int SW     = 2 * CMW,
  localparam int PAYW   = 4 + 3 * CMW + 3 * CW,
  localparam int ENTRYW = SW + PAYW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pfp_pts_if.sink                              pts,
  input  logic [2*pfp_pkg::LIMIT_WIDTH-1:0]    limit_sq,
  input  pfp_pkg::queue_stat_t                 qstat,
  output logic                                 push,
  output logic [ENTRYW-1:0]                    entry
);

  localparam int NSTG = 8;
  localparam int CMPW = (SW > pfp_pkg::THR_WIDTH) ? SW : pfp_pkg::THR_WIDTH;

  logic            f_en;
  logic [NSTG-1:0] v_r;

  logic signed [CW-1:0]    pa [3];
  logic signed [CW-1:0]    pb [3];
  logic signed [CW-1:0]    pc [3];
  logic signed [CW-1:0]    a_r [NSTG][3];
  logic signed [EW-1:0]    e1_r [3];
  logic signed [EW-1:0]    e2_r [3];
  logic signed [2*EW-1:0]  pu_r [3];
  logic signed [2*EW-1:0]  ps_r [3];
  logic signed [CMW:0]     c_r [3];
  logic [CMW-1:0]          cm_r [5][3];
  logic                    cn_r [5][3];
  logic [CMW-1:0]          hh_r [3];
  logic [CMW-1:0]          hl_r [3];
  logic [CMW-1:0]          ll_r [3];
  logic [SW-1:0]           sq_r [3];
  logic [SW-1:0]           s7_r, s8_r;
  logic                    dg_r;
  logic [CMPW-1:0]         thr;

  assign pa[0] = pts.first_x;
  assign pa[1] = pts.first_y;
  assign pa[2] = pts.first_z;
  assign pb[0] = pts.second_x;
  assign pb[1] = pts.second_y;
  assign pb[2] = pts.second_z;
  assign pc[0] = pts.third_x;
  assign pc[1] = pts.third_y;
  assign pc[2] = pts.third_z;

  // The whole front advances together; it only stops when its last stage
  // holds a transaction that the queue cannot take.
  assign f_en      = !v_r[NSTG-1] || !qstat.full;
  assign pts.ready = f_en;
  assign push      = v_r[NSTG-1] && !qstat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (f_en) begin
      v_r <= {v_r[NSTG-2:0], pts.valid};
    end
  end

  assign thr = CMPW'(limit_sq) << (2 * pfp_pkg::COORD_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (f_en) begin
      for (int i = 0; i < 3; i++) begin
        a_r[0][i] <= pa[i];
        e1_r[i]   <= EW'(pb[i]) - EW'(pa[i]);
        e2_r[i]   <= EW'(pc[i]) - EW'(pa[i]);
      end
      for (int k = 1; k < NSTG; k++) begin
        a_r[k] <= a_r[k-1];
      end

      pu_r[0] <= e1_r[1] * e2_r[2];
      ps_r[0] <= e1_r[2] * e2_r[1];
      pu_r[1] <= e1_r[2] * e2_r[0];
      ps_r[1] <= e1_r[0] * e2_r[2];
      pu_r[2] <= e1_r[0] * e2_r[1];
      ps_r[2] <= e1_r[1] * e2_r[0];

      for (int i = 0; i < 3; i++) begin
        c_r[i]     <= (CMW+1)'(pu_r[i]) - (CMW+1)'(ps_r[i]);
        cn_r[0][i] <= c_r[i][CMW];
        cm_r[0][i] <= c_r[i][CMW] ? CMW'(-c_r[i]) : CMW'(c_r[i]);
        // Square of the magnitude from three half-width products.
        hh_r[i] <= cm_r[0][i][CMW-1 -: H] * cm_r[0][i][CMW-1 -: H];
        hl_r[i] <= cm_r[0][i][CMW-1 -: H] * cm_r[0][i][H-1:0];
        ll_r[i] <= cm_r[0][i][H-1:0] * cm_r[0][i][H-1:0];
        sq_r[i] <= (SW'(hh_r[i]) << (2 * H)) + (SW'(hl_r[i]) << (H + 1)) + SW'(ll_r[i]);
      end
      for (int k = 1; k < 5; k++) begin
        cm_r[k] <= cm_r[k-1];
        cn_r[k] <= cn_r[k-1];
      end

      s7_r <= sq_r[0] + sq_r[1] + sq_r[2];
      s8_r <= s7_r;
      dg_r <= (s7_r == '0) || (CMPW'(s7_r) < thr);
    end
  end

  assign entry = {s8_r, dg_r,
                  cn_r[4][2], cn_r[4][1], cn_r[4][0],
                  cm_r[4][2], cm_r[4][1], cm_r[4][0],
                  a_r[NSTG-1][2], a_r[NSTG-1][1], a_r[NSTG-1][0]};

endmodule

// ===== rtl/core/pfp_back.sv =====
// Back pipeline: integer square root, three rounding dividers, offset dot
// product with saturation, and the output register. Depends on pfp_pkg, pfp_ifs.
module pfp_back #(
  parameter int  COORD_WIDTH      = pfp_pkg::DEF_COORD_WIDTH,
  parameter int  NORMAL_FRAC_BITS = pfp_pkg::DEF_NORMAL_FRAC_BITS,
  localparam int CW     = COORD_WIDTH,
  localparam int NF     = NORMAL_FRAC_BITS,
  localparam int CMW    = 2 * CW + 2,
  localparam int SW     = 2 * CMW,
  localparam int PAYW   = 4 + 3 * CMW + 3 * CW,
  localparam int ENTRYW = SW + PAYW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ENTRYW-1:0]    entry,
  input  pfp_pkg::queue_stat_t qstat,
  output logic                 pop,
  pfp_plane_if.source          plane
);

  localparam int LW   = CMW;
  localparam int RW   = LW + 3;
  localparam int NUMW = CMW + NF + 2;
  localparam int QW   = NF + 1;
  localparam int NW   = NF + 2;
  localparam int PW   = NW + CW;
  localparam int AW   = PW + 2;
  localparam int DPW  = 4 + 3 * CW;
  localparam int NB   = LW + QW + 6;
  localparam int A_LO  = 0;
  localparam int CM_LO = 3 * CW;
  localparam int CN_LO = 3 * CW + 3 * CMW;
  localparam int DG_AT = CN_LO + 3;

  localparam logic [AW:0]   RND  = (AW+1)'(1) << (NF - 1);
  localparam logic [AW:0]   MINM = (AW+1)'(1) << (CW - 1);
  localparam logic [AW:0]   MAXP = MINM - (AW+1)'(1);

  logic          b_en;
  logic [NB-1:0] v_r;

  // Square root stages.
  logic [RW-1:0]   sr_r [LW];
  logic [LW-1:0]   rt_r [LW];
  logic [SW-1:0]   ss_r [LW];
  logic [PAYW-1:0] sp_r [LW];

  // Divider set-up and stages.
  logic [LW:0]     den_r;
  logic [NUMW-1:0] num_r [3];
  logic [DPW-1:0]  pp_r;
  logic [NUMW-1:0] dr_r [QW][3];
  logic [QW-1:0]   dq_r [QW][3];
  logic [LW:0]     dd_r [QW];
  logic [DPW-1:0]  dp_r [QW];

  // Offset stages.
  logic signed [NW-1:0] nrm_r [3];
  logic signed [NW-1:0] nrm2_r [3];
  logic signed [NW-1:0] nrm3_r [3];
  logic signed [NW-1:0] nrm4_r [3];
  logic signed [CW-1:0] na_r [3];
  logic                 ndg_r, pdg_r, sdg_r, adg_r;
  logic signed [PW-1:0] pr_r [3];
  logic signed [AW-1:0] acc_r;
  logic                 an_r;
  logic [AW-1:0]        am_r;

  logic [AW:0]          mr;
  logic [CW-1:0]        d_val;

  logic signed [NW-1:0] ox_r, oy_r, oz_r;
  logic signed [CW-1:0] off_r;
  logic                 odg_r;

  logic [LW-1:0]        sq_root;
  logic [PAYW-1:0]      sq_pay;

  assign b_en = !v_r[NB-1] || plane.ready;
  assign pop  = b_en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (b_en) begin
      v_r <= {v_r[NB-2:0], pop};
    end
  end

  // One result bit of floor(sqrt(S)) per stage, most significant first.
  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    localparam int BI = LW - 1 - k;
    logic [RW-1:0]   rem_in, rem_sh, trial;
    logic [LW-1:0]   root_in;
    logic [SW-1:0]   s_in;
    logic [PAYW-1:0] pay_in;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = entry[ENTRYW-1 -: SW];
      assign pay_in  = entry[PAYW-1:0];
    end else begin : g_next
      assign rem_in  = sr_r[k-1];
      assign root_in = rt_r[k-1];
      assign s_in    = ss_r[k-1];
      assign pay_in  = sp_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[RW-3:0], s_in[2*BI+1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (b_en) begin
        sr_r[k] <= ge ? rem_sh - trial : rem_sh;
        rt_r[k] <= {root_in[LW-2:0], ge};
        ss_r[k] <= s_in;
        sp_r[k] <= pay_in;
      end
    end
  end

  assign sq_root = rt_r[LW-1];
  assign sq_pay  = sp_r[LW-1];

  // Rounded quotient: floor((2|c| * 2^NF + L) / 2L).
  always_ff @(posedge clk) begin
    if (b_en) begin
      den_r <= {sq_root, 1'b0};
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUMW'(sq_pay[CM_LO + i*CMW +: CMW]) << (NF + 1)) + NUMW'(sq_root);
      end
      pp_r <= {sq_pay[DG_AT], sq_pay[CN_LO +: 3], sq_pay[A_LO +: 3*CW]};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int KB = QW - 1 - j;
    logic [NUMW-1:0] rem_in [3];
    logic [QW-1:0]   q_in [3];
    logic [LW:0]     den_in;
    logic [DPW-1:0]  pay_in;
    logic [NUMW-1:0] dsh;
    logic [NUMW-1:0] rem_out [3];
    logic [QW-1:0]   q_out [3];

    if (j == 0) begin : g_first
      assign rem_in = num_r;
      assign q_in   = '{default: '0};
      assign den_in = den_r;
      assign pay_in = pp_r;
    end else begin : g_next
      assign rem_in = dr_r[j-1];
      assign q_in   = dq_r[j-1];
      assign den_in = dd_r[j-1];
      assign pay_in = dp_r[j-1];
    end

    always_comb begin
      dsh = NUMW'(den_in) << KB;
      for (int i = 0; i < 3; i++) begin
        q_out[i] = q_in[i];
        if (rem_in[i] >= dsh) begin
          rem_out[i]   = rem_in[i] - dsh;
          q_out[i][KB] = 1'b1;
        end else begin
          rem_out[i] = rem_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (b_en) begin
        dr_r[j] <= rem_out;
        dq_r[j] <= q_out;
        dd_r[j] <= den_in;
        dp_r[j] <= pay_in;
      end
    end
  end

  always_comb begin
    mr = ({1'b0, am_r} + RND) >> NF;
    if (an_r) begin
      d_val = (mr > MAXP) ? MAXP[CW-1:0] : mr[CW-1:0];
    end else begin
      d_val = (mr >= MINM) ? MINM[CW-1:0] : -mr[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      for (int i = 0; i < 3; i++) begin
        nrm_r[i] <= dp_r[QW-1][3*CW + i] ? -$signed({1'b0, dq_r[QW-1][i]})
                                          : $signed({1'b0, dq_r[QW-1][i]});
        na_r[i]  <= dp_r[QW-1][i*CW +: CW];
        pr_r[i]  <= nrm_r[i] * na_r[i];
      end
      ndg_r  <= dp_r[QW-1][DPW-1];
      nrm2_r <= nrm_r;
      pdg_r  <= ndg_r;

      acc_r  <= AW'(pr_r[0]) + AW'(pr_r[1]) + AW'(pr_r[2]);
      nrm3_r <= nrm2_r;
      sdg_r  <= pdg_r;

      an_r   <= acc_r[AW-1];
      am_r   <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
      nrm4_r <= nrm3_r;
      adg_r  <= sdg_r;

      if (adg_r) begin
        ox_r  <= '0;
        oy_r  <= '0;
        oz_r  <= '0;
        off_r <= '0;
      end else begin
        ox_r  <= nrm4_r[0];
        oy_r  <= nrm4_r[1];
        oz_r  <= nrm4_r[2];
        off_r <= d_val;
      end
      odg_r <= adg_r;
    end
  end

  assign plane.valid      = v_r[NB-1];
  assign plane.normal_x   = ox_r;
  assign plane.normal_y   = oy_r;
  assign plane.normal_z   = oz_r;
  assign plane.offset     = off_r;
  assign plane.degenerate = odg_r;

endmodule

// ===== rtl/core/plane_from_three_points.sv =====
// Top level of the plane-from-three-points block: limit register, front and
// back pipelines joined by a queue. Depends on pfp_pkg, pfp_ifs and submodules.
//
//   channel     dir  handshake        payload
//   in_pts      in   valid/ready      three points, signed Q16.16
//   out_plane   out  valid/ready      unit normal Q2.30, offset Q16.16, degenerate
//   cfg_*       in   write enable     degenerate_limit, Q16.16
//
// One transaction is accepted per cycle unless a full queue stalls the front.
// The square root and dividers resolve one bit per stage. Reset is synchronous
// and clears valid bits, queue pointers and the limit (to 7). A stalled output
// halts only the back pipeline; the front keeps accepting until the queue fills.
module plane_from_three_points #(
  parameter int COORD_WIDTH      = pfp_pkg::DEF_COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = pfp_pkg::DEF_NORMAL_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pfp_pts_if.sink                           in_pts,
  pfp_plane_if.source                       out_plane,
  input  logic                              cfg_we,
  input  logic [pfp_pkg::LIMIT_WIDTH-1:0]   cfg_data
);

  localparam int CMW    = 2 * COORD_WIDTH + 2;
  localparam int ENTRYW = 2 * CMW + 4 + 3 * CMW + 3 * COORD_WIDTH;
  localparam int NW     = NORMAL_FRAC_BITS + 2;
  localparam logic signed [NW-1:0] ONE  = NW'(1) << NORMAL_FRAC_BITS;
  localparam logic signed [NW-1:0] MONE = -ONE;
  localparam logic [2*pfp_pkg::LIMIT_WIDTH-1:0] LIMIT_SQ_RESET =
    (2*pfp_pkg::LIMIT_WIDTH)'(pfp_pkg::LIMIT_RESET) *
    (2*pfp_pkg::LIMIT_WIDTH)'(pfp_pkg::LIMIT_RESET);

  logic [pfp_pkg::LIMIT_WIDTH-1:0]   limit_r;
  logic [2*pfp_pkg::LIMIT_WIDTH-1:0] limit_sq_r;

  logic                 push, pop;
  logic [ENTRYW-1:0]    wdata, rdata;
  pfp_pkg::queue_stat_t qstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= pfp_pkg::LIMIT_RESET;
      limit_sq_r <= LIMIT_SQ_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      limit_sq_r <= limit_r * limit_r;
    end
  end

  pfp_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pts      (in_pts),
    .limit_sq (limit_sq_r),
    .qstat    (qstat),
    .push     (push),
    .entry    (wdata)
  );

  pfp_queue #(
    .WIDTH (ENTRYW),
    .DEPTH (pfp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .stat  (qstat)
  );

  pfp_back #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .entry (rdata),
    .qstat (qstat),
    .pop   (pop),
    .plane (out_plane)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pts.ready |-> qstat.full)
    else $error("input stalled while queue has room");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_plane.valid && out_plane.degenerate |->
      out_plane.normal_x == '0 && out_plane.normal_y == '0 &&
      out_plane.normal_z == '0 && out_plane.offset == '0)
    else $error("degenerate plane with nonzero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_plane.valid && !out_plane.degenerate |->
      out_plane.normal_x <= ONE && out_plane.normal_x >= MONE &&
      out_plane.normal_y <= ONE && out_plane.normal_y >= MONE &&
      out_plane.normal_z <= ONE && out_plane.normal_z >= MONE)
    else $error("normal component outside unit range");

endmodule
